// ----- hdl/bicolor_led_row_scan_macros.svh -----
// Assertion macros used by the scan engine sequencer RTL.
`ifndef BICOLOR_LED_ROW_SCAN_MACROS_SVH
`define BICOLOR_LED_ROW_SCAN_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every edge outside reset.
`define BLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every edge outside reset.
`define BLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLR_ASSERT_IMP(lbl, ante, cons, msg)
`define BLR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/blr_pkg.sv -----
// Types and constants of the bicolor LED row scan engine.
`default_nettype none

package blr_pkg;

  localparam int unsigned ROWS     = 8;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DUTY_W   = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned FRAME_W  = 2 * BYTE_W;
  localparam int unsigned DUTYW_W  = 2 * DUTY_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 3'd7;
  localparam logic [0:0]        MODE_WRITE = 1'b0;
  localparam logic [0:0]        MODE_TICK  = 1'b1;

  // One frame row: both colors
  typedef struct packed {
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } frame_word_t;

  // One row's duty counters
  typedef struct packed {
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] red;
  } duty_word_t;

  // Control of one row memory
  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
  } ram_ctl_t;

  // Count set bits of a byte with the folding masks
  function automatic logic [CNT_W-1:0] count_ones(input logic [BYTE_W-1:0] x);
    logic [BYTE_W-1:0] c;
    c = x - ((x >> 1) & 8'h55);
    c = ((c >> 2) & 8'h33) + (c & 8'h33);
    c = ((c >> 4) + c) & 8'h0F;
    return c[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/blr_in_if.sv -----
// Input channel of the scan engine: write rows or refresh ticks.
`default_nettype none

interface blr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [2:0] row_index;
  logic [7:0] red_bits;
  logic [7:0] green_bits;

  modport source (output valid, output mode, output row_index, output red_bits,
                  output green_bits, input ready);
  modport sink   (input valid, input mode, input row_index, input red_bits,
                  input green_bits, output ready);
endinterface

`default_nettype wire

// ----- hdl/blr_out_if.sv -----
// Result channel of the scan engine: shift-register bytes.
`default_nettype none

interface blr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_byte;
  logic       last_byte;

  modport source (output valid, output shift_byte, output last_byte, input ready);
  modport sink   (input valid, input shift_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/blr_row_ram.sv -----
// Eight-row synchronous memory with per-row valid bits that read as zero.
`default_nettype none

module blr_row_ram #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire blr_pkg::ram_ctl_t    ctl,
  input  wire logic [WIDTH-1:0]     wr_data,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0]         mem_r [blr_pkg::ROWS];
  logic [blr_pkg::ROWS-1:0] vld_r;
  logic [WIDTH-1:0]         rd_data_r;

  // Store the row
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= wr_data;
    end
  end

  // Mark rows written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[ctl.wr_addr] <= 1'b1;
    end
  end

  // Register read data; unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= vld_r[ctl.rd_addr] ? mem_r[ctl.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/blr_scan_ctrl.sv -----
// Sequencer: row writes, duty read-modify-write and the three-word output run.
`default_nettype none

`include "bicolor_led_row_scan_macros.svh"

module blr_scan_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  blr_in_if.sink                     in_ch,
  blr_out_if.source                  out_ch,
  output blr_pkg::ram_ctl_t          frame_ctl,
  output blr_pkg::frame_word_t       frame_wdata,
  input  wire blr_pkg::frame_word_t  frame_rdata,
  output blr_pkg::ram_ctl_t          duty_ctl,
  output blr_pkg::duty_word_t        duty_wdata,
  input  wire blr_pkg::duty_word_t   duty_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_GREEN} state_t;

  state_t                            state_r;
  logic [blr_pkg::ROW_W-1:0]         scan_row_r;
  logic                              showing_green_r;
  logic [blr_pkg::BYTE_W-1:0]        shown_r;
  logic                              out_valid_r;
  logic [blr_pkg::BYTE_W-1:0]        out_byte_r;
  logic                              out_last_r;

  logic                              out_free;
  logic                              in_fire;
  logic                              tick_fire;
  logic                              write_fire;
  logic                              calc_go;
  logic                              green_go;
  logic [blr_pkg::BYTE_W-1:0]        row_sel;
  logic [blr_pkg::BYTE_W-1:0]        bits;
  logic [blr_pkg::DUTY_W-1:0]        duty;
  logic [blr_pkg::DUTY_W-1:0]        duty_nxt;
  logic [blr_pkg::BYTE_W-1:0]        shown_nxt;

  // Handshake
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign tick_fire  = in_fire && (in_ch.mode == blr_pkg::MODE_TICK);
  assign write_fire = in_fire && (in_ch.mode == blr_pkg::MODE_WRITE);
  assign calc_go    = (state_r == S_CALC) && out_free;
  assign green_go   = (state_r == S_GREEN) && out_free;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.shift_byte = out_byte_r;
  assign out_ch.last_byte  = out_last_r;

  // Active-low select of the scanned row
  assign row_sel = ~(blr_pkg::BYTE_W'(1) << scan_row_r);

  // Gate the served color by popcount against its duty counter
  always_comb begin
    bits      = showing_green_r ? frame_rdata.green : frame_rdata.red;
    duty      = showing_green_r ? duty_rdata.green : duty_rdata.red;
    shown_nxt = (blr_pkg::count_ones(bits) >= {1'b0, duty}) ? bits : '0;
    duty_nxt  = (duty >= blr_pkg::DUTY_MAX) ? '0 : duty + 1'b1;
  end

  // Frame memory: write rows, read the scanned row on a tick
  always_comb begin
    frame_ctl.wr_en   = write_fire;
    frame_ctl.wr_addr = in_ch.row_index;
    frame_ctl.rd_en   = tick_fire;
    frame_ctl.rd_addr = scan_row_r;
    frame_wdata.red   = in_ch.red_bits;
    frame_wdata.green = in_ch.green_bits;
  end

  // Duty memory: read on a tick, write back the advanced counter
  always_comb begin
    duty_ctl.wr_en   = calc_go;
    duty_ctl.wr_addr = scan_row_r;
    duty_ctl.rd_en   = tick_fire;
    duty_ctl.rd_addr = scan_row_r;
    duty_wdata       = duty_rdata;
    if (showing_green_r) begin
      duty_wdata.green = duty_nxt;
    end else begin
      duty_wdata.red = duty_nxt;
    end
  end

  // Sequence state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      scan_row_r      <= '0;
      showing_green_r <= 1'b0;
      out_valid_r     <= 1'b0;
      out_last_r      <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (tick_fire) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= row_sel;
            out_last_r  <= 1'b0;
            state_r     <= S_CALC;
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_CALC: begin
          if (calc_go) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= showing_green_r ? '0 : shown_nxt;
            out_last_r  <= 1'b0;
            shown_r     <= shown_nxt;
            state_r     <= S_GREEN;
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_GREEN: begin
          if (green_go) begin
            out_valid_r     <= 1'b1;
            out_byte_r      <= showing_green_r ? shown_r : '0;
            out_last_r      <= 1'b1;
            showing_green_r <= !showing_green_r;
            if (showing_green_r) begin
              scan_row_r <= scan_row_r + 1'b1;
            end
            state_r <= S_IDLE;
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  `BLR_ASSERT_NXT(a_tick_starts_run, tick_fire,
                  (state_r == S_CALC) && out_valid_r && !out_last_r,
                  "tick did not start a run with the row select")
  `BLR_ASSERT_NXT(a_last_closes_run, green_go,
                  out_valid_r && out_last_r && (state_r == S_IDLE),
                  "run did not close with the last word")
  `BLR_ASSERT_NXT(a_color_toggles, green_go,
                  showing_green_r != $past(showing_green_r),
                  "served color did not alternate")
  `BLR_ASSERT_NXT(a_row_holds_on_red, green_go && !showing_green_r,
                  $stable(scan_row_r),
                  "scan row advanced after a red tick")
  `BLR_ASSERT_NXT(a_idle_green_zero, green_go && !showing_green_r,
                  out_byte_r == '0,
                  "green byte not zero while red is served")

endmodule

`default_nettype wire

// ----- hdl/bicolor_led_row_scan.sv -----
// Bicolor 8x8 LED matrix row scan engine, top level.
//
// in_ch carries one word per item: mode 0 stores red_bits/green_bits as frame
// row row_index and gives no result; mode 1 is a refresh tick that serves one
// color of the current scan row. out_ch carries the tick's three words in
// order: the active-low row select, the red byte, the green byte (last_byte
// set on the third). Only the served color's byte can be non-zero, and only
// while the row's popcount is at least that color's duty counter.
// The row select word is presented in the cycle after a tick is accepted;
// the red byte follows, then the green byte, each once the prior word is taken.
// The duty memory read-modify-write and the single output register serve one
// tick at a time; a row write starts no run.
// Items are taken only between runs. When the receiver stalls, the output
// word holds and the sequencer waits; no word is dropped.
// Reset (synchronous, rst_n low) clears the valid bits of both row memories,
// so all frame rows and duty counters read as zero, and restarts the scan at
// row 0 with red served first.
`default_nettype none

module bicolor_led_row_scan (
  input  wire logic clk,
  input  wire logic rst_n,
  blr_in_if.sink    in_ch,
  blr_out_if.source out_ch
);

  blr_pkg::ram_ctl_t    frame_ctl;
  blr_pkg::frame_word_t frame_wdata;
  blr_pkg::frame_word_t frame_rdata;
  blr_pkg::ram_ctl_t    duty_ctl;
  blr_pkg::duty_word_t  duty_wdata;
  blr_pkg::duty_word_t  duty_rdata;

  blr_scan_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .frame_ctl   (frame_ctl),
    .frame_wdata (frame_wdata),
    .frame_rdata (frame_rdata),
    .duty_ctl    (duty_ctl),
    .duty_wdata  (duty_wdata),
    .duty_rdata  (duty_rdata)
  );

  // Frame store: red and green bytes per row
  blr_row_ram #(.WIDTH(blr_pkg::FRAME_W)) u_frame_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (frame_ctl),
    .wr_data (frame_wdata),
    .rd_data (frame_rdata)
  );

  // Duty store: red and green counters per row
  blr_row_ram #(.WIDTH(blr_pkg::DUTYW_W)) u_duty_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (duty_ctl),
    .wr_data (duty_wdata),
    .rd_data (duty_rdata)
  );

endmodule

`default_nettype wire

// ----- dv/tb_bicolor_led_row_scan.sv -----
// Testbench for the bicolor LED row scan engine: directed and random traffic with a scoreboard.
`timescale 1ns / 1ps

module tb_bicolor_led_row_scan;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT = 7;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       last_byte;
  } shift_word_t;

  logic clk = 1'b0;
  logic rst_n;

  blr_in_if  in_ch();
  blr_out_if out_ch();

  bicolor_led_row_scan dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the frame store, duty counters and scan position
  logic [7:0] red_rows [8];
  logic [7:0] green_rows [8];
  logic [2:0] red_duty [8];
  logic [2:0] green_duty [8];
  logic [2:0] scan_row;
  logic       green_turn;

  shift_word_t shift_words_due [$];
  int          fails = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          hold_reqs = 0;
  int          holds_taken = 0;
  int          hold_left = 0;

  // Free-running clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [3:0] lit_count(input logic [7:0] bits);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n += bits[i];
    end
    return n;
  endfunction

  // Work out the words a tick produces; a row write only updates the frame
  function automatic void predict_scan(input logic [0:0] mode, input logic [2:0] row,
                                       input logic [7:0] red, input logic [7:0] green);
    logic [2:0] r;
    logic [7:0] shown;
    if (mode == blr_pkg::MODE_WRITE) begin
      red_rows[row] = red;
      green_rows[row] = green;
      return;
    end
    r = scan_row;
    shift_words_due.push_back('{shift_byte: ~(8'h01 << r), last_byte: 1'b0});
    if (!green_turn) begin
      shown = (lit_count(red_rows[r]) >= red_duty[r]) ? red_rows[r] : 8'h00;
      red_duty[r] = red_duty[r] + 3'd1;
      shift_words_due.push_back('{shift_byte: shown, last_byte: 1'b0});
      shift_words_due.push_back('{shift_byte: 8'h00, last_byte: 1'b1});
    end else begin
      shown = (lit_count(green_rows[r]) >= green_duty[r]) ? green_rows[r] : 8'h00;
      green_duty[r] = green_duty[r] + 3'd1;
      shift_words_due.push_back('{shift_byte: 8'h00, last_byte: 1'b0});
      shift_words_due.push_back('{shift_byte: shown, last_byte: 1'b1});
      scan_row = r + 3'd1;
    end
    green_turn = ~green_turn;
  endfunction

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_scan(in_ch.mode, in_ch.row_index, in_ch.red_bits, in_ch.green_bits);
    end
  end

  // Compare every accepted output word against the oldest prediction
  always @(posedge clk) begin
    shift_word_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (shift_words_due.size() == 0) begin
        $error("unexpected word: shift_byte %02h last_byte %0b",
               out_ch.shift_byte, out_ch.last_byte);
        fails++;
      end else begin
        due = shift_words_due.pop_front();
        if (out_ch.shift_byte !== due.shift_byte) begin
          $error("shift_byte: expected %02h, actual %02h", due.shift_byte, out_ch.shift_byte);
          fails++;
        end
        if (out_ch.last_byte !== due.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", due.last_byte, out_ch.last_byte);
          fails++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold when one is requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_taken) begin
        holds_taken = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input logic [0:0] mode, input logic [2:0] row,
                           input logic [7:0] red, input logic [7:0] green);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.row_index  <= row;
    in_ch.red_bits   <= red;
    in_ch.green_bits <= green;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Tick with random content in the fields the block ignores
  task automatic send_tick();
    send_word(blr_pkg::MODE_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Byte with a random number of lit LEDs, so popcounts spread over 0..8
  function automatic logic [7:0] lit_pattern();
    logic [7:0] bits;
    bits = 8'h00;
    repeat ($urandom_range(0, 8)) bits[$urandom_range(0, 7)] = 1'b1;
    return bits;
  endfunction

  // Mostly ticks, with row writes mixed in
  task automatic send_random_item();
    if ($urandom_range(0, 99) < 75) begin
      send_tick();
    end else if ($urandom_range(0, 3) == 0) begin
      send_word(blr_pkg::MODE_WRITE, 3'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      send_word(blr_pkg::MODE_WRITE, 3'($urandom), lit_pattern(), lit_pattern());
    end
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shift_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Ticks on the cleared frame: row 0 select, all color bytes zero
  task automatic test_reset_state();
    send_tick();
    send_tick();
  endtask

  // Full, empty and mixed rows, a write to the row being scanned, and a full scan
  task automatic test_row_patterns();
    send_word(blr_pkg::MODE_WRITE, 3'd1, 8'hFF, 8'h00);
    send_word(blr_pkg::MODE_WRITE, 3'd2, 8'h00, 8'hFF);
    send_word(blr_pkg::MODE_WRITE, 3'd7, 8'h81, 8'h7E);
    send_tick();
    send_word(blr_pkg::MODE_WRITE, 3'd1, 8'h0F, 8'hF0);
    repeat (13) send_tick();
  endtask

  task automatic test_random_traffic();
    repeat (140) send_random_item();
  endtask

  // Both sides without idling
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (40) send_random_item();
    calm = 1'b0;
  endtask

  // Receiver holds off while ticks keep coming, so the input stalls
  task automatic test_receiver_hold();
    hold_reqs++;
    calm = 1'b1;
    repeat (20) send_tick();
    calm = 1'b0;
  endtask

  // Sender pauses mid-stream until all output has drained
  task automatic test_drain_pause();
    repeat (10) send_random_item();
    wait_drained();
    repeat (10) send_random_item();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      red_rows[i] = 8'h00;
      green_rows[i] = 8'h00;
      red_duty[i] = 3'd0;
      green_duty[i] = 3'd0;
    end
    scan_row = 3'd0;
    green_turn = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= blr_pkg::MODE_WRITE;
    in_ch.row_index  <= 3'd0;
    in_ch.red_bits   <= 8'h00;
    in_ch.green_bits <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_row_patterns();
    test_random_traffic();
    test_back_to_back();
    test_receiver_hold();
    test_drain_pause();
    wait_drained();

    if (shift_words_due.size() != 0) begin
      $error("%0d predicted words never came out", shift_words_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
